FILE: rtl/core/spnh_pkg.sv
// Shared types and constants for the shortest path next hop block.
`default_nettype none

package spnh_pkg;

  localparam int NODE_BITS      = 3;
  localparam int WEIGHT_IN_BITS = 24;
  localparam int CFG_INDEX_BITS = 2;
  localparam int ADJ_BITS       = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_NODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ADJACENCY   = 2'd1;

  // Input opcodes
  localparam logic OP_WRITE_WEIGHT = 1'b0;
  localparam logic OP_QUERY        = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_UNREACHABLE = 2'd1;
  localparam logic [1:0] STATUS_IS_SOURCE   = 2'd2;

  typedef struct packed {
    logic                      opcode;
    logic [NODE_BITS-1:0]      node_index;
    logic [WEIGHT_IN_BITS-1:0] weight_value;
    logic [NODE_BITS-1:0]      destination;
  } in_word_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] next_hop;
    logic [1:0]           status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_COMMIT,
    ST_WALK_START,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 accept;
    logic                 init;
    logic                 scan_step;
    logic                 commit;
    logic                 walk_init;
    logic                 walk_step;
    logic                 load_result;
    logic [1:0]           result_status;
    logic [NODE_BITS-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic query_bad;
    logic query_self;
    logic best_have;
    logic dest_reached;
    logic parent_is_src;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/spnh_dp.sv
// Datapath: node weights, path costs, parent links, selection and relaxation.
`default_nettype none

module spnh_dp #(
  parameter int NODES       = 8,
  parameter int WEIGHT_BITS = 24
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  spnh_pkg::in_word_t                     in_data,
  input  wire                                    cfg_valid,
  input  wire [spnh_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire [spnh_pkg::ADJ_BITS-1:0]           cfg_data,
  input  spnh_pkg::dp_cmd_t                      cmd,
  output spnh_pkg::dp_status_t                   status,
  output spnh_pkg::out_word_t                    out_data
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CW    = WEIGHT_BITS + 3;

  logic [WEIGHT_BITS-1:0]            weight_r [NODES];
  logic [CW-1:0]                     cost_r   [NODES];
  logic [IDX_W-1:0]                  parent_r [NODES];
  logic [NODES-1:0]                  reached_r;
  logic [NODES-1:0]                  done_r;
  logic [spnh_pkg::NODE_BITS-1:0]    src_r;
  logic [spnh_pkg::ADJ_BITS-1:0]     adj_r;
  logic [spnh_pkg::NODE_BITS-1:0]    dest_r;
  logic                              best_have_r;
  logic                              best_reached_r;
  logic [CW-1:0]                     best_cost_r;
  logic [IDX_W-1:0]                  sel_r;
  logic [IDX_W-1:0]                  walk_node_r;
  spnh_pkg::out_word_t               out_r;

  logic [IDX_W-1:0]                  scan_idx;
  logic [IDX_W-1:0]                  src_idx;
  logic [IDX_W-1:0]                  dest_idx;
  logic                              cand_reached;
  logic [CW-1:0]                     cand_cost;
  logic                              take;
  logic [CW-1:0]                     relax_sum [NODES];
  logic [NODES-1:0]                  relax_hit;
  logic [spnh_pkg::NODE_BITS-1:0]    sel_wide;
  logic [IDX_W-1:0]                  walk_parent;
  logic                              in_node_ok;

  assign scan_idx     = cmd.idx[IDX_W-1:0];
  assign src_idx      = src_r[IDX_W-1:0];
  assign dest_idx     = dest_r[IDX_W-1:0];
  assign cand_reached = reached_r[scan_idx];
  assign cand_cost    = cost_r[scan_idx];
  assign sel_wide     = spnh_pkg::NODE_BITS'(sel_r);
  assign walk_parent  = parent_r[walk_node_r];
  assign in_node_ok   = int'(in_data.node_index) < NODES;

  // Selection: smallest reached cost, unreached counts as infinite, ties go high.
  always_comb begin
    if (done_r[scan_idx]) begin
      take = 1'b0;
    end else if (!best_have_r) begin
      take = 1'b1;
    end else if (cand_reached) begin
      take = !best_reached_r || (cand_cost <= best_cost_r);
    end else begin
      take = !best_reached_r;
    end
  end

  // Relax every neighbor of the selected node at once; a tie replaces the path.
  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      relax_sum[j] = best_cost_r + CW'(weight_r[j]);
      relax_hit[j] = (IDX_W'(j) != sel_r) && !done_r[j] &&
                     adj_r[{sel_wide, spnh_pkg::NODE_BITS'(j)}] &&
                     (!reached_r[j] || (relax_sum[j] <= cost_r[j]));
    end
  end

  assign status.query_bad     = (int'(src_r) >= NODES) || (int'(dest_r) >= NODES);
  assign status.query_self    = dest_r == src_r;
  assign status.best_have     = best_have_r;
  assign status.dest_reached  = reached_r[dest_idx];
  assign status.parent_is_src = spnh_pkg::NODE_BITS'(walk_parent) == src_r;

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NODES; j++) begin
        weight_r[j] <= '0;
      end
      reached_r   <= '0;
      done_r      <= '0;
      src_r       <= '0;
      adj_r       <= '0;
      best_have_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          spnh_pkg::CFG_SOURCE_NODE: src_r <= cfg_data[spnh_pkg::NODE_BITS-1:0];
          spnh_pkg::CFG_ADJACENCY:   adj_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept && in_data.opcode == spnh_pkg::OP_WRITE_WEIGHT && in_node_ok) begin
        weight_r[in_data.node_index[IDX_W-1:0]] <= WEIGHT_BITS'(in_data.weight_value);
      end
      if (cmd.init) begin
        done_r      <= '0;
        // only the source starts out reached
        reached_r   <= {{(NODES-1){1'b0}}, 1'b1} << src_idx;
        best_have_r <= 1'b0;
      end
      if (cmd.scan_step && take) begin
        best_have_r <= 1'b1;
      end
      if (cmd.commit) begin
        done_r[sel_r] <= 1'b1;
        best_have_r   <= 1'b0;
        if (best_reached_r) begin
          reached_r <= reached_r | relax_hit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dest_r <= in_data.destination;
    end
    if (cmd.init) begin
      cost_r[src_idx]   <= '0;
      parent_r[src_idx] <= src_idx;
    end
    if (cmd.scan_step && take) begin
      best_reached_r <= cand_reached;
      best_cost_r    <= cand_cost;
      sel_r          <= scan_idx;
    end
    if (cmd.commit && best_reached_r) begin
      for (int j = 0; j < NODES; j++) begin
        if (relax_hit[j]) begin
          cost_r[j]   <= relax_sum[j];
          parent_r[j] <= sel_r;
        end
      end
    end
    if (cmd.walk_init) begin
      walk_node_r <= dest_idx;
    end
    if (cmd.walk_step) begin
      walk_node_r <= walk_parent;
    end
    if (cmd.load_result) begin
      out_r.status   <= cmd.result_status;
      out_r.next_hop <= (cmd.result_status == spnh_pkg::STATUS_OK) ?
                        spnh_pkg::NODE_BITS'(walk_node_r) : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/spnh_ctrl.sv
// Controller: sequences the node scan, relax, parent walk and result word.
`default_nettype none

module spnh_ctrl #(
  parameter int NODES = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_opcode,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  output spnh_pkg::dp_cmd_t     cmd,
  input  spnh_pkg::dp_status_t  status
);

  localparam int               IDX_W      = $clog2(NODES);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NODES - 1);
  localparam logic [IDX_W-1:0] LAST_ROUND = IDX_W'(NODES - 2);

  spnh_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] round_r, round_nxt;
  logic [1:0]       result_r, result_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spnh_pkg::ST_IDLE;
      idx_r       <= '0;
      round_r     <= '0;
      result_r    <= spnh_pkg::STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      round_r     <= round_nxt;
      result_r    <= result_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    round_nxt         = round_r;
    result_nxt        = result_r;
    cmd               = '0;
    cmd.result_status = result_r;
    cmd.idx           = spnh_pkg::NODE_BITS'(idx_r);

    unique case (state_r)
      spnh_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_opcode == spnh_pkg::OP_QUERY) begin
            state_nxt = spnh_pkg::ST_CHECK;
          end
        end
      end
      spnh_pkg::ST_CHECK: begin
        if (status.query_bad) begin
          result_nxt = spnh_pkg::STATUS_UNREACHABLE;
          state_nxt  = spnh_pkg::ST_FINISH;
        end else if (status.query_self) begin
          result_nxt = spnh_pkg::STATUS_IS_SOURCE;
          state_nxt  = spnh_pkg::ST_FINISH;
        end else begin
          cmd.init  = 1'b1;
          idx_nxt   = '0;
          round_nxt = '0;
          state_nxt = spnh_pkg::ST_SCAN;
        end
      end
      spnh_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = spnh_pkg::ST_COMMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      spnh_pkg::ST_COMMIT: begin
        // no candidate left: stop the rounds early
        if (!status.best_have) begin
          state_nxt = spnh_pkg::ST_WALK_START;
        end else begin
          cmd.commit = 1'b1;
          if (round_r == LAST_ROUND) begin
            state_nxt = spnh_pkg::ST_WALK_START;
          end else begin
            round_nxt = round_r + 1'b1;
            idx_nxt   = '0;
            state_nxt = spnh_pkg::ST_SCAN;
          end
        end
      end
      spnh_pkg::ST_WALK_START: begin
        if (!status.dest_reached) begin
          result_nxt = spnh_pkg::STATUS_UNREACHABLE;
          state_nxt  = spnh_pkg::ST_FINISH;
        end else begin
          cmd.walk_init = 1'b1;
          result_nxt    = spnh_pkg::STATUS_OK;
          idx_nxt       = '0;
          state_nxt     = spnh_pkg::ST_WALK;
        end
      end
      spnh_pkg::ST_WALK: begin
        if (status.parent_is_src) begin
          state_nxt = spnh_pkg::ST_FINISH;
        end else begin
          cmd.walk_step = 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = spnh_pkg::ST_FINISH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      spnh_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.load_result = 1'b1;
          state_nxt       = spnh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spnh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = state_r != spnh_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/shortest_path_next_hop.sv
// Top level of the shortest path next hop block.
`default_nettype none

// Keeps one load weight per node and answers next-hop queries by running
// dense Dijkstra from the configured source over the configured adjacency
// matrix, where entering a node costs its weight. A weight write word leaves
// the block ready for the next word. A query whose source or destination
// is out of range, or whose destination is the source, is answered without
// a search. Any other query holds off further words while each selection
// round scans the nodes one per cycle through a single compare unit, then
// relaxes all neighbors of the selected node at once, and the
// parent walk follows one link per cycle. A finished query also holds for as
// long as an earlier result still sits stalled in the output register. The
// result sits in an output register, so the next word is taken while a result
// waits to be taken.
// Configuration writes are always ready and must only be issued while idle.
module shortest_path_next_hop #(
  parameter int NODES       = 8,
  parameter int WEIGHT_BITS = 24
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  spnh_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output spnh_pkg::out_word_t                  out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [spnh_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [spnh_pkg::ADJ_BITS-1:0]         cfg_data
);

  spnh_pkg::dp_cmd_t    cmd;
  spnh_pkg::dp_status_t dp_stat;

  assign cfg_ready = 1'b1;

  spnh_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (dp_stat)
  );

  spnh_dp #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (dp_stat),
    .out_data  (out_data)
  );

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.init, cmd.scan_step, cmd.commit,
              cmd.walk_init, cmd.walk_step, cmd.load_result}))
    else $error("datapath commands overlap");

  a_hop_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != spnh_pkg::STATUS_OK) |-> out_data.next_hop == '0)
    else $error("next hop not zero on error status");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a query in progress");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == spnh_pkg::OP_QUERY) |=> in_stall)
    else $error("query accepted without going busy");

endmodule

`default_nettype wire

FILE: test/shortest_path_next_hop_checker.sv
// Route predictor and result checker for the shortest path next hop block.
`timescale 1ns / 100ps

module shortest_path_next_hop_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  spnh_pkg::in_word_t                 in_data,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  spnh_pkg::out_word_t                out_data,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire [spnh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [spnh_pkg::ADJ_BITS-1:0]       cfg_data,
  output int                                 fail_count,
  output int                                 pending_count
);
  import spnh_pkg::*;

  localparam int NODE_COUNT = 8;
  localparam int COST_BITS  = 27;

  logic [WEIGHT_IN_BITS-1:0] hop_weight [NODE_COUNT];
  logic [NODE_BITS-1:0]      route_src;
  logic [ADJ_BITS-1:0]       route_adj;
  out_word_t                 expected_routes [$];
  int                        fails = 0;

  // Dense Dijkstra from route_src, then walk parents back to the first hop.
  function automatic out_word_t predict_route(logic [NODE_BITS-1:0] dest);
    logic [COST_BITS-1:0] cost [NODE_COUNT];
    bit                   settled [NODE_COUNT];
    bit                   seen [NODE_COUNT];
    logic [NODE_BITS-1:0] parent [NODE_COUNT];
    bit                   have;
    bit                   best_seen;
    bit                   take;
    logic [COST_BITS-1:0] best_cost;
    logic [COST_BITS-1:0] sum;
    logic [NODE_BITS-1:0] sel;
    logic [NODE_BITS-1:0] n;
    out_word_t            r;
    r.next_hop = '0;
    r.status   = STATUS_OK;
    if (dest == route_src) begin
      r.status = STATUS_IS_SOURCE;
      return r;
    end
    for (int i = 0; i < NODE_COUNT; i++) begin
      cost[i]    = '0;
      settled[i] = 1'b0;
      seen[i]    = 1'b0;
      parent[i]  = '0;
    end
    seen[route_src]   = 1'b1;
    parent[route_src] = route_src;
    for (int round = 0; round < NODE_COUNT - 1; round++) begin
      have      = 1'b0;
      best_seen = 1'b0;
      best_cost = '0;
      sel       = '0;
      // Unreached counts as infinite; ties go to the highest index.
      for (int j = 0; j < NODE_COUNT; j++) begin
        if (!settled[j]) begin
          if (!have) take = 1'b1;
          else if (seen[j]) take = !best_seen || (cost[j] <= best_cost);
          else take = !best_seen;
          if (take) begin
            have      = 1'b1;
            sel       = NODE_BITS'(j);
            best_seen = seen[j];
            best_cost = cost[j];
          end
        end
      end
      if (!have) break;
      settled[sel] = 1'b1;
      if (seen[sel]) begin
        for (int j = 0; j < NODE_COUNT; j++) begin
          if (!settled[j] && route_adj[int'(sel) * 8 + j]) begin
            sum = cost[sel] + COST_BITS'(hop_weight[j]);
            // Equal cost replaces the old path.
            if (!seen[j] || sum <= cost[j]) begin
              seen[j]   = 1'b1;
              cost[j]   = sum;
              parent[j] = sel;
            end
          end
        end
      end
    end
    if (!seen[dest]) begin
      r.status = STATUS_UNREACHABLE;
      return r;
    end
    n = dest;
    for (int k = 0; k < NODE_COUNT; k++) begin
      if (parent[n] == route_src) break;
      n = parent[n];
    end
    r.next_hop = n;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT; i++) hop_weight[i] = '0;
      route_src = '0;
      route_adj = '0;
      expected_routes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SOURCE_NODE: route_src = cfg_data[NODE_BITS-1:0];
          CFG_ADJACENCY:   route_adj = cfg_data;
          default: ;
        endcase
      end
      // Pop before push: a result taken now belongs to an older query.
      if (out_valid && !out_stall) begin
        if (expected_routes.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result hop %0d status %0d",
                     $realtime, out_data.next_hop, out_data.status);
          fails++;
        end else begin
          want = expected_routes.pop_front();
          if (out_data.next_hop !== want.next_hop || out_data.status !== want.status) begin
            if (fails < 10)
              $display("%0t: mismatch: expected hop %0d status %0d, got hop %0d status %0d",
                       $realtime, want.next_hop, want.status,
                       out_data.next_hop, out_data.status);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OP_WRITE_WEIGHT) hop_weight[in_data.node_index] = in_data.weight_value;
        else expected_routes.push_back(predict_route(in_data.destination));
      end
    end
    fail_count    <= fails;
    pending_count <= expected_routes.size();
  end

endmodule

FILE: test/shortest_path_next_hop_tb.sv
// Stimulus and verdict for the shortest path next hop block.
`timescale 1ns / 100ps

module shortest_path_next_hop_tb;
  import spnh_pkg::*;

  localparam int IDLE_LIMIT       = 2000;
  localparam int SETTLE_CYCLES    = 100;
  localparam int PHASES           = 7;
  localparam int ITEMS_PER_PHASE  = 250;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_word_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_word_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [ADJ_BITS-1:0]       cfg_data = '0;
  int                        fail_count;
  int                        pending_count;
  int                        idle_cycles = 0;
  int                        stall_left = 0;
  bit                        sender_busy = 1'b0;

  shortest_path_next_hop u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  shortest_path_next_hop_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side for a random number of valid cycles after each word.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("shortest_path_next_hop_tb failed");
      $finish;
    end
  end

  function automatic in_word_t make_word(logic op, int idx, logic [WEIGHT_IN_BITS-1:0] w,
                                         int dest);
    in_word_t x;
    x.opcode       = op;
    x.node_index   = NODE_BITS'(idx);
    x.weight_value = w;
    x.destination  = NODE_BITS'(dest);
    return x;
  endfunction

  function automatic logic [WEIGHT_IN_BITS-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return WEIGHT_IN_BITS'($urandom);
      1: return WEIGHT_IN_BITS'($urandom_range(0, 3));   // force cost ties
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return WEIGHT_IN_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ADJ_BITS-1:0] pick_adjacency();
    logic [ADJ_BITS-1:0] a;
    logic [ADJ_BITS-1:0] b;
    logic [ADJ_BITS-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '1;
      1: return a;
      2: return a & b & c;
      3: return a | b;
      4: return a & b;
      default: return '0;
    endcase
  endfunction

  // Drop valid for one cycle after the write so the next write starts on a fresh edge.
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [ADJ_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(in_word_t w);
    int gap;
    gap = sender_busy ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Hold off until every result is back and the block has gone quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_word_t            w;
    logic [ADJ_BITS-1:0] line_graph;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: no links, source 0.
    send_word(make_word(OP_QUERY, 0, '0, 0));
    send_word(make_word(OP_QUERY, 7, '1, 5));
    send_word(make_word(OP_WRITE_WEIGHT, 0, '1, 0));
    send_word(make_word(OP_WRITE_WEIGHT, 7, '0, 7));

    // Full mesh from the top node; many equal costs.
    wait_idle();
    write_reg(CFG_SOURCE_NODE, ADJ_BITS'(7));
    write_reg(CFG_ADJACENCY, '1);
    send_word(make_word(OP_QUERY, 0, '0, 0));
    send_word(make_word(OP_QUERY, 0, '0, 3));
    send_word(make_word(OP_WRITE_WEIGHT, 3, '1, 0));
    send_word(make_word(OP_WRITE_WEIGHT, 1, 24'd1, 0));
    send_word(make_word(OP_QUERY, 0, '0, 3));
    send_word(make_word(OP_QUERY, 0, '0, 7));
    send_word(make_word(OP_WRITE_WEIGHT, 6, '1, 0));

    // Chain 0 -> 1 -> ... -> 7 -> 0.
    wait_idle();
    line_graph = '0;
    for (int i = 0; i < 7; i++) line_graph[i * 8 + i + 1] = 1'b1;
    line_graph[56] = 1'b1;
    write_reg(CFG_SOURCE_NODE, '0);
    write_reg(CFG_ADJACENCY, line_graph);
    send_word(make_word(OP_QUERY, 0, '0, 7));
    send_word(make_word(OP_QUERY, 0, '0, 1));
    send_word(make_word(OP_WRITE_WEIGHT, 4, '0, 0));
    send_word(make_word(OP_QUERY, 0, '0, 4));

    // Unused register indexes must leave the routes alone.
    wait_idle();
    write_reg(CFG_SOURCE_NODE, ADJ_BITS'(3));
    write_reg(CFG_ADJACENCY, {$urandom, $urandom});
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, {$urandom, $urandom});
    send_word(make_word(OP_QUERY, 0, '0, 2));
    send_word(make_word(OP_QUERY, 0, '0, 6));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_SOURCE_NODE, {$urandom, $urandom});
      write_reg(CFG_ADJACENCY, pick_adjacency());
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, $urandom});
      sender_busy = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        w.opcode       = 1'($urandom_range(0, 1));
        w.node_index   = NODE_BITS'($urandom);
        w.weight_value = pick_weight();
        w.destination  = NODE_BITS'($urandom);
        send_word(w);
        if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          drain_results();
        end
      end
    end
    sender_busy = 1'b0;

    in_valid <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("shortest_path_next_hop_tb passed");
    end else begin
      $display("shortest_path_next_hop_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/spnh_pkg.sv
rtl/core/spnh_dp.sv
rtl/core/spnh_ctrl.sv
rtl/core/shortest_path_next_hop.sv
test/shortest_path_next_hop_checker.sv
test/shortest_path_next_hop_tb.sv
